// File: sv/smaf_pkg.sv
// Shared types and constants of the sliding median converter filter.
// No dependencies; imported by the interfaces and every module of the block.
package smaf_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int GAIN_W     = 24;
	localparam int MED_W      = 13;
	localparam int VOLT_W     = 16;
	localparam int PROD_W     = MED_W + GAIN_W;
	localparam int VOLT_SHIFT = 17;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd52802;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [GAIN_W-1:0]   gain_t;
	typedef logic [MED_W-1:0]    med_t;
	typedef logic [VOLT_W-1:0]   volt_t;
	typedef logic [PROD_W-1:0]   prod_t;

	// Controller to datapath commands
	typedef struct packed {
		logic take; // request accepted this edge: ring write and old-entry read
		logic del;  // drop the evicted value from the sorted cells
		logic ins;  // insert the new sample into the sorted cells
		logic med;  // register twice the median
		logic mul;  // register the gain product
		logic load; // load the result register
	} smaf_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free; // result register can take a new result this edge
	} smaf_stat_t;

endpackage

// File: sv/smaf_if.sv
// Valid/ready channel interfaces for sample requests and result requests.
// Depends on smaf_pkg for the payload types.
interface smaf_sample_if;
	import smaf_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface smaf_result_if;
	import smaf_pkg::*;

	logic  valid;
	logic  ready;
	med_t  median_twice;
	volt_t voltage_mv;
	logic  voltage_saturated;

	modport source (output valid, output median_twice, output voltage_mv,
		output voltage_saturated, input ready);
	modport sink   (input valid, input median_twice, input voltage_mv,
		input voltage_saturated, output ready);
endinterface

// File: sv/smaf_ctrl.sv
// Sequencing state machine of the median filter.
// Depends on smaf_pkg for the command and status structs.
module smaf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  smaf_pkg::smaf_stat_t stat,
	output logic                 in_ready,
	output smaf_pkg::smaf_cmd_t  cmd
);
	import smaf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEL,
		ST_INS,
		ST_MED,
		ST_MUL,
		ST_LOAD
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   del_q;
	logic   ins_q;
	logic   med_q;
	logic   mul_q;
	logic   load_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
			del_q   <= 1'b0;
			ins_q   <= 1'b0;
			med_q   <= 1'b0;
			mul_q   <= 1'b0;
			load_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DEL;
						ready_q <= 1'b0;
						del_q   <= 1'b1;
					end
				end
				ST_DEL: begin
					state_q <= ST_INS;
					del_q   <= 1'b0;
					ins_q   <= 1'b1;
				end
				ST_INS: begin
					state_q <= ST_MED;
					ins_q   <= 1'b0;
					med_q   <= 1'b1;
				end
				ST_MED: begin
					state_q <= ST_MUL;
					med_q   <= 1'b0;
					mul_q   <= 1'b1;
				end
				ST_MUL: begin
					state_q <= ST_LOAD;
					mul_q   <= 1'b0;
					load_q  <= 1'b1;
				end
				ST_LOAD: begin
					// hold until the result register frees up
					if (stat.out_free) begin
						state_q <= ST_IDLE;
						load_q  <= 1'b0;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
					del_q   <= 1'b0;
					ins_q   <= 1'b0;
					med_q   <= 1'b0;
					mul_q   <= 1'b0;
					load_q  <= 1'b0;
				end
			endcase
		end
	end

	assign in_ready = ready_q;

	always_comb begin
		cmd.take = in_valid & ready_q;
		cmd.del  = del_q;
		cmd.ins  = ins_q;
		cmd.med  = med_q;
		cmd.mul  = mul_q;
		cmd.load = load_q;
	end

endmodule

// File: sv/smaf_dpath.sv
// Datapath: sample ring memory, sorted cell chain, median add, gain multiply,
// saturation and result register. Depends on smaf_pkg.
module smaf_dpath #(
	parameter int WINDOW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  smaf_pkg::smaf_cmd_t  cmd,
	output smaf_pkg::smaf_stat_t stat,
	input  smaf_pkg::sample_t    in_sample,
	input  logic                 cfg_we,
	input  smaf_pkg::gain_t      cfg_wdata,
	input  logic                 out_ready,
	output logic                 out_valid,
	output smaf_pkg::med_t       out_median_twice,
	output smaf_pkg::volt_t      out_voltage_mv,
	output logic                 out_voltage_saturated
);
	import smaf_pkg::*;

	localparam int ADDR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int MED_HI = WINDOW / 2;
	localparam int MED_LO = (WINDOW % 2 == 0) ? (WINDOW / 2 - 1) : (WINDOW / 2);
	localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(WINDOW - 1);

	// ---- ring memory, one write and one registered read per request ----
	sample_t           ring_mem [WINDOW];
	logic [WINDOW-1:0] ring_vld_q;
	logic [ADDR_W-1:0] wptr_q;
	sample_t           old_q;
	logic              old_vld_q;
	sample_t           new_q;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			ring_mem[wptr_q] <= in_sample;
			old_q            <= ring_mem[wptr_q];
			new_q            <= in_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_vld_q <= '0;
			wptr_q     <= '0;
			old_vld_q  <= 1'b0;
		end else if (cmd.take) begin
			ring_vld_q[wptr_q] <= 1'b1;
			old_vld_q          <= ring_vld_q[wptr_q];
			wptr_q             <= (wptr_q == LAST_POS) ? '0 : wptr_q + 1'b1;
		end
	end

	// ---- sorted cell chain, ascending; one delete step then one insert ----
	sample_t sort_q  [WINDOW];
	sample_t del_val [WINDOW];
	sample_t ins_val [WINDOW];
	sample_t old_val;

	// never-written entries count as zero readings
	assign old_val = old_vld_q ? old_q : '0;

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		// delete the highest copy of the old value; the top cell is left vacant
		if (i < WINDOW - 1) begin : g_del
			assign del_val[i] = (sort_q[i+1] > old_val) ? sort_q[i+1] : sort_q[i];
		end else begin : g_del_top
			assign del_val[i] = sort_q[i];
		end

		// insert into the lower cells, vacant top cell acts as +infinity
		if (WINDOW == 1) begin : g_ins_one
			assign ins_val[i] = new_q;
		end else if (i == 0) begin : g_ins_low
			assign ins_val[i] = (sort_q[i] > new_q) ? new_q : sort_q[i];
		end else if (i == WINDOW - 1) begin : g_ins_top
			assign ins_val[i] = (sort_q[i-1] > new_q) ? sort_q[i-1] : new_q;
		end else begin : g_ins_mid
			assign ins_val[i] = (sort_q[i-1] > new_q) ? sort_q[i-1] :
				(sort_q[i] > new_q) ? new_q : sort_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WINDOW; k++) begin
				sort_q[k] <= '0;
			end
		end else if (cmd.del) begin
			sort_q <= del_val;
		end else if (cmd.ins) begin
			sort_q <= ins_val;
		end
	end

	// ---- gain register ----
	gain_t gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_we) begin
			gain_q <= cfg_wdata;
		end
	end

	// ---- median, product ----
	med_t  med2_q;
	prod_t prod_q;

	always_ff @(posedge clk) begin
		if (cmd.med) begin
			med2_q <= {1'b0, sort_q[MED_LO]} + {1'b0, sort_q[MED_HI]};
		end
		if (cmd.mul) begin
			prod_q <= {{GAIN_W{1'b0}}, med2_q} * {{MED_W{1'b0}}, gain_q};
		end
	end

	// ---- saturation and result register ----
	logic [PROD_W-VOLT_SHIFT-1:0] volt_full;
	logic                         volt_sat;
	logic                         out_valid_q;
	med_t                         res_med_q;
	volt_t                        res_volt_q;
	logic                         res_sat_q;
	logic                         out_free;

	assign volt_full = prod_q[PROD_W-1:VOLT_SHIFT];
	assign volt_sat  = |volt_full[PROD_W-VOLT_SHIFT-1:VOLT_W];
	assign out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && out_free) begin
			res_med_q  <= med2_q;
			res_volt_q <= volt_sat ? {VOLT_W{1'b1}} : volt_full[VOLT_W-1:0];
			res_sat_q  <= volt_sat;
		end
	end

	assign stat.out_free         = out_free;
	assign out_valid             = out_valid_q;
	assign out_median_twice      = res_med_q;
	assign out_voltage_mv        = res_volt_q;
	assign out_voltage_saturated = res_sat_q;

endmodule

// File: sv/sliding_median_adc_filter_unit.sv
// Top level of the sliding-window median filter for a 12-bit converter.
// Depends on smaf_pkg, smaf_if, smaf_ctrl and smaf_dpath.
//
//   channel   dir   payload                                        handshake
//   samples   in    sample[11:0]                                   valid/ready
//   results   out   median_twice[12:0], voltage_mv[15:0],          valid/ready
//                   voltage_saturated
//   cfg       in    cfg_wdata[23:0] (millivolt gain, Q16)          cfg_we, no wait
//
// Requests are taken one at a time: accept edge (ring write and old-entry
// read), then delete and insert in the sorted cell chain, median add, gain
// multiply, and the result load; no new request is taken before the result
// is loaded. A stalled result holds the last step and input ready stays low
// until the result register frees up.
// Reset (arst_n low) clears the ring valid bits, write pointer, sorted cells
// and the gain (52802); no clearing pass is needed.
module sliding_median_adc_filter_unit #(
	parameter int WINDOW = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	smaf_sample_if.sink            samples,
	smaf_result_if.source          results,
	input  logic                   cfg_we,
	input  smaf_pkg::gain_t        cfg_wdata
);
	import smaf_pkg::*;

	smaf_cmd_t  cmd;
	smaf_stat_t stat;
	logic       in_ready;

	// sequencer: one request in flight at a time
	smaf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.stat     (stat),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	assign samples.ready = in_ready;

	// ring, sorted cells, arithmetic and result register
	smaf_dpath #(
		.WINDOW (WINDOW)
	) u_dpath (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cmd                   (cmd),
		.stat                  (stat),
		.in_sample             (samples.sample),
		.cfg_we                (cfg_we),
		.cfg_wdata             (cfg_wdata),
		.out_ready             (results.ready),
		.out_valid             (results.valid),
		.out_median_twice      (results.median_twice),
		.out_voltage_mv        (results.voltage_mv),
		.out_voltage_saturated (results.voltage_saturated)
	);

`ifndef ASSERT_OFF
	// no second request while one is being worked on
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		samples.ready |-> !(cmd.del || cmd.ins || cmd.med || cmd.mul || cmd.load))
		else $error("request accepted while a previous one is in flight");

	// acceptance starts the delete step on the next edge
	a_take_then_del: assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready) |=> cmd.del)
		else $error("accepted request did not start the cell update");

	// the insert always follows the delete so the cell chain keeps its size
	a_del_then_ins: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.del |=> cmd.ins)
		else $error("cell delete not followed by insert");
`endif

endmodule
